[rtl/cde_pkg.sv]
// Shared constants, types and controller state codes for the channel delay equalizer.
`default_nettype none
package cde_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 32;
  localparam int unsigned DELAY_W          = 14;
  localparam int unsigned SETTING_W        = 15;

  localparam logic [DELAY_W-1:0] DELAY_ALL_ONES = 14'h3fff;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } cde_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // item accepted this cycle
    logic scan_rd;  // issue read for the max scan
    logic ptr_clr;  // rewind the read pointer
    logic emit_rd;  // issue read for an output item
    logic out_load; // load the output register
    logic set_clr;  // set done: clear count and minimum
  } cde_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_last;  // read pointer is at the last stored channel
    logic out_last; // held output item is the last of the set
    logic out_acc;  // output item taken this cycle
  } cde_sts_t;

endpackage
`default_nettype wire

[rtl/cde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cde_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/cde_datapath.sv]
// Datapath: delay store, channel count, running min/max, output register.
`default_nettype none
module cde_datapath #(
  parameter int unsigned MAX_CHANNELS = cde_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cde_pkg::cde_cmd_t                  cmd,
  output cde_pkg::cde_sts_t                       sts,
  input  wire logic [cde_pkg::DELAY_W-1:0]        in_measured_delay,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic signed [cde_pkg::SETTING_W-1:0]    out_setting,
  output logic                                    out_last_setting
);

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned DW = cde_pkg::DELAY_W;
  localparam int unsigned SW = cde_pkg::SETTING_W;

  logic [CW-1:0]        count_r, count_nxt;
  logic [DW-1:0]        min_r, min_nxt;
  logic signed [SW-1:0] max_r, max_nxt;
  logic [AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic                 cmp_vld_r, cmp_first_r, emit_last_r;
  logic                 out_vld_r, out_vld_nxt;
  logic signed [SW-1:0] out_setting_r;
  logic                 out_last_r;

  logic                 not_full;
  logic                 wr_en;
  logic [DW-1:0]        wr_val;
  logic [DW-1:0]        rd_data;
  logic [DW-1:0]        diff14;
  logic signed [SW-1:0] diff;

  assign not_full = (count_r != CW'(MAX_CHANNELS));
  assign wr_en    = cmd.load && not_full;
  // channel slip, modulo 2^14
  assign wr_val   = in_measured_delay - DW'(count_r);

  cde_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count_r[AW-1:0]),
    .wdata(wr_val),
    .raddr(rd_ptr_r),
    .rdata(rd_data)
  );

  // stored - min, read as 14-bit two's complement
  assign diff14 = rd_data - min_r;
  assign diff   = $signed({diff14[DW-1], diff14});

  always_comb begin
    count_nxt  = count_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      count_nxt = count_r + CW'(1);
      if (wr_val < min_r) begin
        min_nxt = wr_val;
      end
    end
    if (cmp_vld_r && (cmp_first_r || (diff > max_r))) begin
      max_nxt = diff;
    end
    if (cmd.scan_rd || cmd.emit_rd) begin
      rd_ptr_nxt = rd_ptr_r + AW'(1);
    end
    if (cmd.ptr_clr || cmd.set_clr) begin
      rd_ptr_nxt = '0;
    end
    if (cmd.set_clr) begin
      count_nxt = '0;
      min_nxt   = cde_pkg::DELAY_ALL_ONES;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (sts.out_acc) begin
      out_vld_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= cde_pkg::DELAY_ALL_ONES;
      max_r       <= '0;
      rd_ptr_r    <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_first_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cmp_vld_r   <= cmd.scan_rd;
      cmp_first_r <= (rd_ptr_r == '0);
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      emit_last_r <= sts.rd_last;
    end
    if (cmd.out_load) begin
      out_setting_r <= diff - max_r;
      out_last_r    <= emit_last_r;
    end
  end

  assign sts.rd_last  = (CW'(rd_ptr_r) == CW'(count_r - CW'(1)));
  assign sts.out_last = out_last_r;
  assign sts.out_acc  = out_vld_r && !out_stall;

  assign out_valid        = out_vld_r;
  assign out_setting      = out_setting_r;
  assign out_last_setting = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_vld_r)
    else $error("output register loaded while an item is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CHANNELS))
    else $error("channel count beyond store depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_clr |=> (count_r == '0) && (min_r == cde_pkg::DELAY_ALL_ONES))
    else $error("set clear did not restore count and minimum");

  a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_setting_r <= 0))
    else $error("positive equalizer setting");

endmodule
`default_nettype wire

[rtl/cde_ctrl.sv]
// Controller state machine: load, max scan and output sequencing.
`default_nettype none
module cde_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_channel,
  output logic                   in_stall,
  output cde_pkg::cde_cmd_t      cmd,
  input  wire cde_pkg::cde_sts_t sts
);

  cde_pkg::cde_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cde_pkg::ST_LOAD: begin
        if (in_valid && in_last_channel) begin
          state_nxt = cde_pkg::ST_SCAN;
        end
      end
      cde_pkg::ST_SCAN: begin
        if (sts.rd_last) begin
          state_nxt = cde_pkg::ST_DRAIN;
        end
      end
      cde_pkg::ST_DRAIN:   state_nxt = cde_pkg::ST_EMIT_RD;
      cde_pkg::ST_EMIT_RD: state_nxt = cde_pkg::ST_EMIT_LD;
      cde_pkg::ST_EMIT_LD: state_nxt = cde_pkg::ST_EMIT_WAIT;
      cde_pkg::ST_EMIT_WAIT: begin
        if (sts.out_acc) begin
          state_nxt = sts.out_last ? cde_pkg::ST_LOAD : cde_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = cde_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      cde_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      cde_pkg::ST_SCAN:    cmd.scan_rd  = 1'b1;
      cde_pkg::ST_DRAIN:   cmd.ptr_clr  = 1'b1;
      cde_pkg::ST_EMIT_RD: cmd.emit_rd  = 1'b1;
      cde_pkg::ST_EMIT_LD: cmd.out_load = 1'b1;
      cde_pkg::ST_EMIT_WAIT: begin
        cmd.set_clr = sts.out_acc && sts.out_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cde_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/channel_delay_equalizer_core.sv]
// Top level of the channel delay equalizer: controller plus datapath.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------------
//  in      | input     | in_measured_delay[13:0], in_last_channel | in_valid/in_stall
//  out     | output    | out_setting[14:0] (signed), out_last_setting | out_valid/out_stall
//
// Loading takes one item per cycle; in_stall is low only in the load state.
// After the last item, the max scan reads each of the n stored channels in turn
// (one store read port, registered read) and then drains; each result then passes
// the read, load and wait states, and waits for as long as out_stall is held.
// Items beyond MAX_CHANNELS are dropped; a dropped last item still ends the set.
// rst_n is synchronous, active low; the store itself is not cleared.
`default_nettype none
module channel_delay_equalizer_core #(
  parameter int unsigned MAX_CHANNELS = cde_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [cde_pkg::DELAY_W-1:0]     in_measured_delay,
  input  wire logic                            in_last_channel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [cde_pkg::SETTING_W-1:0] out_setting,
  output logic                                 out_last_setting
);

  cde_pkg::cde_cmd_t cmd;
  cde_pkg::cde_sts_t sts;

  // sequencing: load, scan for max, emit one item at a time
  cde_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_channel(in_last_channel),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .sts            (sts)
  );

  // store, min/max tracking and output register
  cde_datapath #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_measured_delay(in_measured_delay),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_setting      (out_setting),
    .out_last_setting (out_last_setting)
  );

endmodule
`default_nettype wire

[sim/cde_equalizer_checker.sv]
// Checker for the channel delay equalizer: predicts each set's settings and compares results.
module cde_equalizer_checker
  import cde_pkg::*;
#(
  parameter int unsigned NCH = MAX_CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [DELAY_W-1:0]          in_measured_delay,
  input  wire logic                        in_last_channel,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic signed [SETTING_W-1:0] out_setting,
  input  wire logic                        out_last_setting,
  output int                               settings_pending,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SETTING_W-1:0] setting;
    logic                        last;
  } eq_setting_t;

  logic [DELAY_W-1:0] slip_store [NCH];
  int unsigned        fill;
  logic [DELAY_W-1:0] slip_floor;
  eq_setting_t        settings_due [$];

  // Store one slip-corrected reading; the final channel turns the set into settings.
  task automatic take_reading(input logic [DELAY_W-1:0] raw, input logic closes);
    logic signed [SETTING_W-1:0] offset [NCH];
    logic signed [SETTING_W-1:0] peak;
    logic [DELAY_W-1:0]          rel;
    eq_setting_t                 due;
    if (fill < NCH) begin
      slip_store[fill] = raw - DELAY_W'(fill);
      if (slip_store[fill] < slip_floor) slip_floor = slip_store[fill];
      fill++;
    end
    if (closes) begin
      peak = '0;
      for (int unsigned i = 0; i < fill; i++) begin
        rel = slip_store[i] - slip_floor;
        offset[i] = {rel[DELAY_W-1], rel};  // 14-bit two's complement, widened
        if (i == 0 || offset[i] > peak) peak = offset[i];
      end
      for (int unsigned i = 0; i < fill; i++) begin
        due.setting = offset[i] - peak;
        due.last    = (i + 1 == fill);
        settings_due.push_back(due);
      end
      fill       = 0;
      slip_floor = '1;
    end
  endtask

  always @(posedge clk) begin
    eq_setting_t due;
    if (!rst_n) begin
      fill       = 0;
      slip_floor = '1;
      mismatches = 0;
      settings_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (settings_due.size() == 0) begin
          $error("out_setting: expected nothing, actual %0d", out_setting);
          mismatches++;
        end else begin
          due = settings_due.pop_front();
          if (out_setting !== due.setting) begin
            $error("out_setting: expected %0d, actual %0d", $signed(due.setting), out_setting);
            mismatches++;
          end
          if (out_last_setting !== due.last) begin
            $error("out_last_setting: expected %0d, actual %0d", due.last, out_last_setting);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) take_reading(in_measured_delay, in_last_channel);
    end
    settings_pending <= settings_due.size();
  end

endmodule

[sim/tb.sv]
// Testbench top: drives delay sets into the equalizer, stalls results, gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cde_pkg::*;

  localparam int unsigned NCH         = MAX_CHANNELS_DEF;
  localparam int unsigned ITEM_TARGET = 320;
  // A full set emits up to 32 results, each slowed by the longest stalls; even if
  // every item cost as much as such a result, ~360 items stay well below this.
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef enum int unsigned {
    STYLE_SPREAD,   // any 14-bit reading
    STYLE_ALIGNED,  // base + channel index + small jitter, as a real link would
    STYLE_CORNER    // only the range ends and the sign boundary
  } reading_style_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [DELAY_W-1:0]          in_measured_delay;
  logic                        in_last_channel;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [SETTING_W-1:0] out_setting;
  logic                        out_last_setting;

  int          settings_pending;
  int          mismatches;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  always #4 clk = ~clk;

  channel_delay_equalizer_core #(
    .MAX_CHANNELS(NCH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_measured_delay(in_measured_delay),
    .in_last_channel  (in_last_channel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_setting      (out_setting),
    .out_last_setting (out_last_setting)
  );

  cde_equalizer_checker #(
    .NCH(NCH)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_measured_delay(in_measured_delay),
    .in_last_channel  (in_last_channel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_setting      (out_setting),
    .out_last_setting (out_last_setting),
    .settings_pending (settings_pending),
    .mismatches       (mismatches)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[channel_delay_equalizer_core] ERROR");
      $finish;
    end
  end

  // Present one item and hold it until taken. in_stall is read right after
  // the edge, so it is the value the block saw at that edge. Valid is only
  // dropped when a gap is drawn, so it never toggles within one step.
  task automatic send_reading(input logic [DELAY_W-1:0] raw, input logic closes,
                              input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_measured_delay <= raw;
    in_last_channel   <= closes;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Hold the input idle until every predicted setting has come out.
  // The first edge lets the checker's count catch up with the last item.
  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (settings_pending != 0) @(posedge clk);
  endtask

  // One set of len channels; only the final one carries the last flag.
  // Sets longer than the store exercise the dropped-reading path.
  task automatic send_set(input int unsigned len, input reading_style_t style);
    logic [DELAY_W-1:0] base;
    logic [DELAY_W-1:0] raw;
    bit                 no_gaps;
    int                 jitter;
    base    = DELAY_W'($urandom);
    no_gaps = ($urandom_range(0, 3) == 0);  // some sets go back to back
    for (int unsigned ch = 0; ch < len; ch++) begin
      case (style)
        STYLE_ALIGNED: begin
          jitter = int'($urandom_range(0, 64)) - 32;
          raw    = DELAY_W'(int'(base) + int'(ch) + jitter);
        end
        STYLE_CORNER: begin
          case ($urandom_range(0, 3))
            0:       raw = '0;
            1:       raw = '1;
            2:       raw = 14'h2000;
            default: raw = 14'h1fff;
          endcase
        end
        default: raw = DELAY_W'($urandom);
      endcase
      send_reading(raw, ch + 1 == len, no_gaps);
    end
  endtask

  // Result side: a fresh stall count per item, with calm stretches where
  // results are taken as soon as they appear.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 2) == 0);
      hold = calm ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned    sets_done;
    int unsigned    len;
    reading_style_t style;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_measured_delay <= '0;
    in_last_channel   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Single-channel sets at both ends of the range.
    send_reading(14'h0000, 1'b1, 1'b0);
    send_reading(14'h3fff, 1'b1, 1'b0);
    // Slip brings channel 1 to 0x3ffe: the difference reads as -2.
    send_reading(14'h0000, 1'b0, 1'b0);
    send_reading(14'h3fff, 1'b1, 1'b0);
    // Difference lands exactly on the sign bit: most negative offset.
    send_reading(14'h0000, 1'b0, 1'b0);
    send_reading(14'h2001, 1'b1, 1'b0);
    // Difference just below the sign bit: largest positive offset.
    send_reading(14'h0000, 1'b0, 1'b0);
    send_reading(14'h2000, 1'b1, 1'b0);
    // Slip subtraction wraps below zero.
    send_reading(14'h0005, 1'b0, 1'b0);
    send_reading(14'h0000, 1'b0, 1'b0);
    send_reading(14'h0001, 1'b1, 1'b0);
    // Perfectly aligned channels: every setting is zero.
    send_reading(14'd100, 1'b0, 1'b1);
    send_reading(14'd101, 1'b0, 1'b1);
    send_reading(14'd102, 1'b0, 1'b1);
    send_reading(14'd103, 1'b1, 1'b1);
    // Top reading then zero: both wrap to the same slipped value.
    send_reading(14'h3fff, 1'b0, 1'b0);
    send_reading(14'h0000, 1'b1, 1'b0);

    // Let everything drain before the random part starts.
    await_drain();

    sets_done = 0;
    while (items_sent < ITEM_TARGET) begin
      // Early sets force an exactly full store and an overfull one.
      if (sets_done == 1) begin
        len = NCH;
      end else if (sets_done == 3) begin
        len = $urandom_range(NCH + 1, NCH + 4);
      end else begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(NCH, NCH + 4);
          1, 2:    len = $urandom_range(9, NCH - 1);
          default: len = $urandom_range(1, 8);
        endcase
      end
      style = reading_style_t'($urandom_range(0, 2));
      send_set(len, style);
      sets_done++;
      if ($urandom_range(0, 3) == 0) await_drain();
    end

    await_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[channel_delay_equalizer_core] OK");
    end else begin
      $display("[channel_delay_equalizer_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cde_pkg.sv
rtl/cde_ram.sv
rtl/cde_datapath.sv
rtl/cde_ctrl.sv
rtl/channel_delay_equalizer_core.sv
sim/cde_equalizer_checker.sv
sim/tb.sv
